FILE: rtl/gpf_pkg.sv
// shared types and constants for the geo prefix filter and rate limiter
package gpf_pkg;

    localparam int PrefixEntries = 64;
    localparam int CountrySlots  = 1024;
    localparam int PidxW = $clog2(PrefixEntries);
    localparam int CidxW = $clog2(CountrySlots);

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_PREFIX = 2'd1;
    localparam logic [1:0] CMD_POLICY = 2'd2;

    localparam logic [1:0] KIND_DROP = 2'd1;
    localparam logic [1:0] KIND_RATE = 2'd2;

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
    localparam logic [3:0]  MIN_IHL         = 4'd5;
    localparam logic [5:0]  ADDR_BITS       = 6'd32;

    localparam logic [3:0] R_DISABLED     = 4'd0;
    localparam logic [3:0] R_NOT_IPV4     = 4'd1;
    localparam logic [3:0] R_BAD_IHL      = 4'd2;
    localparam logic [3:0] R_NO_MATCH     = 4'd3;
    localparam logic [3:0] R_ALLOW        = 4'd4;
    localparam logic [3:0] R_COUNTRY_DROP = 4'd5;
    localparam logic [3:0] R_WITHIN       = 4'd6;
    localparam logic [3:0] R_OVER         = 4'd7;
    localparam logic [3:0] R_WRITE        = 4'd8;

    localparam int InW = 2 + 32 + 6 + 10 + 2 + 32 + 6 + 1 + 16 + 4 + 16 + 64;
    localparam int InBytesW = ((InW + 7) / 8) * 8;

    // work handed from front to back
    typedef enum logic [1:0] {
        JOB_DONE,    // verdict already known
        JOB_PREFIX,  // prefix table write
        JOB_POLICY,  // policy table write
        JOB_LOOKUP   // prefix search then policy
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        drop;
        logic [3:0]  reason;
        logic [31:0] ip;
        logic [5:0]  plen;
        logic [9:0]  country;
        logic [1:0]  act;
        logic [31:0] lim;
        logic [5:0]  idx;
        logic        vld;
        logic [63:0] now;
    } job_t;

    typedef struct packed {
        logic       drop;
        logic [3:0] reason;
        logic       geo_drop;
        logic [9:0] country;
    } verdict_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_POLICY_RD,
        ST_POLICY,
        ST_CNT,
        ST_EMIT
    } back_state_t;

endpackage

FILE: rtl/gpf_ram.sv
// generic single write port RAM with registered read
module gpf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/gpf_front.sv
// front end: accepts items, settles early verdicts, feeds the job queue
module gpf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gpf_pkg::InW-1:0]    in_data,
    input  logic                       filter_enable,
    output logic                       q_valid,
    input  logic                       q_pop,
    output gpf_pkg::job_t              q_job
);
    logic [1:0]  cmd;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [15:0] flen;
    gpf_pkg::job_t job;
    gpf_pkg::job_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;

    assign cmd   = in_data[1:0];
    assign etype = in_data[106:91];
    assign ihl   = in_data[110:107];
    assign flen  = in_data[126:111];

    always_comb begin
        job.ip      = in_data[33:2];
        job.plen    = in_data[39:34];
        job.country = in_data[49:40];
        job.act     = in_data[51:50];
        job.lim     = in_data[83:52];
        job.idx     = in_data[89:84];
        job.vld     = in_data[90];
        job.now     = in_data[190:127];
        job.kind    = gpf_pkg::JOB_DONE;
        job.drop    = 1'b0;
        job.reason  = gpf_pkg::R_WRITE;
        unique case (cmd)
            gpf_pkg::CMD_PREFIX: job.kind = gpf_pkg::JOB_PREFIX;
            gpf_pkg::CMD_POLICY: job.kind = gpf_pkg::JOB_POLICY;
            gpf_pkg::CMD_PACKET: begin
                if (!filter_enable) begin
                    job.reason = gpf_pkg::R_DISABLED;
                end else if (etype != gpf_pkg::ETHERTYPE_IPV4 ||
                             flen < gpf_pkg::MIN_FRAME_BYTES) begin
                    job.reason = gpf_pkg::R_NOT_IPV4;
                end else if (ihl < gpf_pkg::MIN_IHL) begin
                    job.reason = gpf_pkg::R_BAD_IHL;
                    job.drop   = 1'b1;
                end else begin
                    job.kind = gpf_pkg::JOB_LOOKUP;
                end
            end
            default: ;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_job    = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) cnt_next = cnt_reg + 2'd1;
        if (!push && q_pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= job;
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push)  wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end
endmodule

FILE: rtl/gpf_back.sv
// back end: prefix scan, policy lookup and window counter update
module gpf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  gpf_pkg::job_t         q_job,
    input  logic [31:0]           window_ns,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gpf_pkg::verdict_t     out_verdict
);
    localparam int PW = gpf_pkg::PidxW;
    localparam int CW = gpf_pkg::CidxW;

    gpf_pkg::back_state_t state_reg, state_next;
    gpf_pkg::job_t     job_reg, job_next;
    gpf_pkg::verdict_t res_reg, res_next;
    logic [PW-1:0] scan_reg, scan_next;
    logic          found_reg, found_next;
    logic [5:0]    best_reg, best_next;
    logic [9:0]    best_c_reg, best_c_next;
    logic [gpf_pkg::PrefixEntries-1:0] pvalid_reg;
    logic          pv_reg;
    // clearing pass address over policy and counter memories after reset
    logic [CW-1:0] cnt_clr_reg, cnt_clr_next;
    logic          ovalid_reg, ovalid_next;
    logic          clearing;

    // prefix memory: addr, length, country
    logic          pf_we;
    logic [PW-1:0] pf_raddr;
    logic [47:0]   pf_rdata;
    // policy memory: kind, limit
    logic          pol_we;
    logic [CW-1:0] pol_waddr;
    logic [33:0]   pol_wdata;
    logic [33:0]   pol_rdata;
    // counter memory: valid, start, count
    logic          ct_we;
    logic [CW-1:0] ct_waddr;
    logic [96:0]   ct_wdata, ct_rdata;

    logic [31:0] mask, p_addr;
    logic [5:0]  p_len;
    logic        hit;
    logic [63:0] elapsed;
    logic [31:0] cnt_inc;
    logic [CW-1:0] cidx;

    assign cidx     = job_reg.country[CW-1:0];
    assign clearing = (state_reg == gpf_pkg::ST_CLEAR);

    assign pol_waddr = clearing ? cnt_clr_reg : q_job.country[CW-1:0];
    assign pol_wdata = clearing ? 34'd0 : {q_job.act, q_job.lim};
    assign ct_waddr  = clearing ? cnt_clr_reg : cidx;

    gpf_ram #(.Width(48), .Depth(gpf_pkg::PrefixEntries)) u_pfx (
        .aclk, .we(pf_we), .waddr(q_job.idx[PW-1:0]),
        .wdata({q_job.ip, q_job.plen, q_job.country}),
        .raddr(pf_raddr), .rdata(pf_rdata));

    // read address is the best match, settled from the policy read state on
    gpf_ram #(.Width(34), .Depth(gpf_pkg::CountrySlots)) u_pol (
        .aclk, .we(pol_we), .waddr(pol_waddr),
        .wdata(pol_wdata),
        .raddr(best_c_reg[CW-1:0]), .rdata(pol_rdata));

    gpf_ram #(.Width(97), .Depth(gpf_pkg::CountrySlots)) u_cnt (
        .aclk, .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
        .raddr(cidx), .rdata(ct_rdata));

    assign pf_raddr = scan_reg;
    assign p_addr   = pf_rdata[47:16];
    assign p_len    = (pf_rdata[15:10] > gpf_pkg::ADDR_BITS) ? gpf_pkg::ADDR_BITS
                                                             : pf_rdata[15:10];
    assign mask     = (p_len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - p_len));
    assign hit      = ((job_reg.ip & mask) == (p_addr & mask));
    assign elapsed  = job_reg.now - ct_rdata[95:32];
    assign cnt_inc  = (ct_rdata[31:0] == 32'hFFFF_FFFF) ? ct_rdata[31:0]
                                                        : ct_rdata[31:0] + 32'd1;

    assign out_valid   = ovalid_reg;
    assign out_verdict = res_reg;

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        res_next     = res_reg;
        scan_next    = scan_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        best_c_next  = best_c_reg;
        ovalid_next  = ovalid_reg;
        cnt_clr_next = cnt_clr_reg;
        q_pop        = 1'b0;
        pf_we        = 1'b0;
        pol_we       = 1'b0;
        ct_we        = 1'b0;
        ct_wdata     = {1'b1, job_reg.now, 32'd1};
        if (ovalid_reg && out_ready) ovalid_next = 1'b0;

        unique case (state_reg)
            gpf_pkg::ST_CLEAR: begin
                pol_we       = 1'b1;
                ct_we        = 1'b1;
                ct_wdata     = '0;
                cnt_clr_next = cnt_clr_reg + 1'b1;
                if (cnt_clr_reg == CW'(gpf_pkg::CountrySlots - 1))
                    state_next = gpf_pkg::ST_IDLE;
            end
            gpf_pkg::ST_IDLE: begin
                // a held verdict must leave before the next item overwrites it
                if (q_valid && (!ovalid_reg || out_ready)) begin
                    q_pop      = 1'b1;
                    job_next   = q_job;
                    res_next   = '{drop: q_job.drop, reason: q_job.reason,
                                   geo_drop: 1'b0, country: 10'd0};
                    scan_next  = '0;
                    found_next = 1'b0;
                    best_next  = 6'd0;
                    best_c_next = 10'd0;
                    unique case (q_job.kind)
                        gpf_pkg::JOB_PREFIX: begin
                            pf_we = ({26'd0, q_job.idx} < gpf_pkg::PrefixEntries);
                            state_next = gpf_pkg::ST_EMIT;
                        end
                        gpf_pkg::JOB_POLICY: begin
                            pol_we = ({22'd0, q_job.country} < gpf_pkg::CountrySlots);
                            state_next = gpf_pkg::ST_EMIT;
                        end
                        gpf_pkg::JOB_LOOKUP: state_next = gpf_pkg::ST_SCAN;
                        default: state_next = gpf_pkg::ST_EMIT;
                    endcase
                end
            end
            gpf_pkg::ST_SCAN, gpf_pkg::ST_SCAN_LAST: begin
                // data of entry scan_reg-1 arrives; skip on first cycle
                if (state_reg == gpf_pkg::ST_SCAN_LAST || scan_reg != '0) begin
                    if (pv_reg && hit &&
                        (!found_reg || p_len > best_reg)) begin
                        found_next  = 1'b1;
                        best_next   = p_len;
                        best_c_next = pf_rdata[9:0];
                    end
                end
                if (state_reg == gpf_pkg::ST_SCAN_LAST) begin
                    state_next = gpf_pkg::ST_POLICY_RD;
                end else begin
                    scan_next = scan_reg + 1'b1;
                    if (scan_reg == PW'(gpf_pkg::PrefixEntries - 1))
                        state_next = gpf_pkg::ST_SCAN_LAST;
                end
            end
            gpf_pkg::ST_POLICY_RD: begin
                job_next.country = best_c_reg;
                if (!found_reg) begin
                    res_next.reason = gpf_pkg::R_NO_MATCH;
                    state_next = gpf_pkg::ST_EMIT;
                end else begin
                    res_next.country = best_c_reg;
                    state_next = gpf_pkg::ST_POLICY;
                end
            end
            gpf_pkg::ST_POLICY: begin
                state_next = gpf_pkg::ST_EMIT;
                res_next.reason = gpf_pkg::R_ALLOW;
                if ({22'd0, job_reg.country} < gpf_pkg::CountrySlots) begin
                    if (pol_rdata[33:32] == gpf_pkg::KIND_DROP) begin
                        res_next.drop = 1'b1;
                        res_next.geo_drop = 1'b1;
                        res_next.reason = gpf_pkg::R_COUNTRY_DROP;
                    end else if (pol_rdata[33:32] == gpf_pkg::KIND_RATE) begin
                        res_next.reason = gpf_pkg::R_WITHIN;
                        job_next.lim = pol_rdata[31:0];
                        if (pol_rdata[31:0] != 32'd0) state_next = gpf_pkg::ST_CNT;
                    end
                end
            end
            gpf_pkg::ST_CNT: begin
                ct_we = 1'b1;
                state_next = gpf_pkg::ST_EMIT;
                if (ct_rdata[96] && elapsed < {32'd0, window_ns}) begin
                    ct_wdata = {1'b1, ct_rdata[95:32], cnt_inc};
                    if (cnt_inc > job_reg.lim) begin
                        res_next.drop = 1'b1;
                        res_next.geo_drop = 1'b1;
                        res_next.reason = gpf_pkg::R_OVER;
                    end
                end
            end
            gpf_pkg::ST_EMIT: begin
                if (!ovalid_reg || out_ready) begin
                    ovalid_next = 1'b1;
                    state_next = gpf_pkg::ST_IDLE;
                end
            end
            default: state_next = gpf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        res_reg    <= res_next;
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        best_c_reg <= best_c_next;
        found_reg  <= found_next;
        pv_reg     <= pvalid_reg[pf_raddr];
        if (!aresetn) begin
            state_reg   <= gpf_pkg::ST_CLEAR;
            ovalid_reg  <= 1'b0;
            pvalid_reg  <= '0;
            cnt_clr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            cnt_clr_reg <= cnt_clr_next;
            if (pf_we) pvalid_reg[q_job.idx[PW-1:0]] <= q_job.vld;
        end
    end
endmodule

FILE: rtl/geo_prefix_filter_rate_limiter_unit.sv
// top level of the geo prefix filter and rate limiter
// Usage: one item enters on the s_ stream and one verdict leaves on the m_ stream.
// s_axis_tdata carries command, addresses, policy fields, header fields and time;
// m_axis_tdata carries drop, reason, geo_drop and matched_country.
// Writes to the prefix table (command 1) and the policy table (command 2) are
// acknowledged with reason 8. Writes, unused commands and early verdicts (filter off,
// not IPv4, short frame, bad ihl) skip the search and pass from the queue slot to the
// back's result register and EMIT state before being offered. A searched packet walks
// all 64 prefix entries, one per cycle through the prefix RAM read port, then reads
// the policy RAM and may do a read-modify-write of the window counter RAM. The back
// takes one item at a time and finishes it before taking the next.
// A two-entry queue between the front classifier and the back engine takes items ahead.
// After reset the back clears all 1024 entries of the policy and counter RAMs, one per
// cycle; prefix entries start invalid, and the queue still takes two items meanwhile.
// When m_axis_tready is low, the result is held and the back waits before taking the
// next item; the front keeps accepting until its queue is full.
// Configuration: cfg_we, cfg_addr (0 filter_enable, 1 window_ns), cfg_wdata; write
// only while nothing is in flight.
module geo_prefix_filter_rate_limiter_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // cmd, src_ip, prefix_len, country, policy_action, packet_limit, entry_index,
    // entry_valid, ethertype, ihl, frame_len, now_ns
    input  logic [gpf_pkg::InBytesW-1:0] s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // drop, reason, geo_drop, matched_country
    output logic [15:0]   m_axis_tdata,
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [31:0]   cfg_wdata
);
    logic        enable_reg;
    logic [31:0] window_reg;
    logic        q_valid, q_pop;
    gpf_pkg::job_t     q_job;
    gpf_pkg::verdict_t verdict;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            window_reg <= 32'd1000000000;
        end else if (cfg_we) begin
            if (cfg_addr == gpf_pkg::REG_ENABLE) enable_reg <= cfg_wdata[0];
            else window_reg <= cfg_wdata;
        end
    end

    gpf_front u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata[gpf_pkg::InW-1:0]),
        .filter_enable(enable_reg),
        .q_valid, .q_pop, .q_job);

    gpf_back u_back (
        .aclk, .aresetn, .q_valid, .q_pop, .q_job,
        .window_ns(window_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_verdict(verdict));

    assign m_axis_tdata = {verdict.country, verdict.geo_drop, verdict.reason, verdict.drop};

    a_drop_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[4:1] == gpf_pkg::R_BAD_IHL ||
             m_axis_tdata[4:1] == gpf_pkg::R_COUNTRY_DROP ||
             m_axis_tdata[4:1] == gpf_pkg::R_OVER))
        else $error("drop with passing reason");
    a_geo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[0])
        else $error("geo drop without drop");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
endmodule

FILE: test/geo_prefix_filter_rate_limiter_unit_test.sv
// testbench for the geo prefix filter and rate limiter: directed table, then random checked items
`timescale 1ns / 1ps

module geo_prefix_filter_rate_limiter_unit_test;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] ACT_ALLOW = 2'd0;
    localparam logic [1:0] ACT_ALLOW_ALT = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 600;

    // packed from msb down, so cmd lands in the lowest bits
    typedef struct packed {
        logic [63:0] now;
        logic [15:0] flen;
        logic [3:0]  ihl;
        logic [15:0] etype;
        logic        vld;
        logic [5:0]  idx;
        logic [31:0] lim;
        logic [1:0]  act;
        logic [9:0]  ctry;
        logic [5:0]  plen;
        logic [31:0] ip;
        logic [1:0]  cmd;
    } item_t;

    typedef struct packed {
        logic [9:0] ctry;
        logic       geo;
        logic [3:0] reason;
        logic       drop;
    } verdict_bits_t;

    typedef struct {
        logic          is_cfg;
        logic          reg_idx;
        logic [31:0]   reg_val;
        item_t         it;
        logic          has_exp;
        verdict_bits_t exp;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic cfg_we;
    logic cfg_addr;
    logic [31:0] cfg_wdata;

    geo_prefix_filter_rate_limiter_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic        enable_q;
    logic [31:0] window_q;
    logic [31:0] pf_addr[gpf_pkg::PrefixEntries];
    logic [5:0]  pf_len[gpf_pkg::PrefixEntries];
    logic [9:0]  pf_ctry[gpf_pkg::PrefixEntries];
    logic        pf_vld[gpf_pkg::PrefixEntries];
    logic [1:0]  pol_kind[gpf_pkg::CountrySlots];
    logic [31:0] pol_lim[gpf_pkg::CountrySlots];
    logic [63:0] win_start[gpf_pkg::CountrySlots];
    logic [31:0] win_count[gpf_pkg::CountrySlots];
    logic        cnt_vld[gpf_pkg::CountrySlots];

    verdict_bits_t verdict_q[$];
    row_t rows[$];
    int mismatches = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic [63:0] clock_ns = 64'd0;

    function automatic verdict_bits_t judge_item(input item_t it);
        verdict_bits_t v;
        logic found;
        int best;
        int l;
        logic [31:0] m;
        logic [9:0] c;
        v = '0;
        found = 1'b0;
        best = 0;
        c = '0;
        if (it.cmd == gpf_pkg::CMD_PREFIX) begin
            pf_addr[it.idx] = it.ip;
            pf_len[it.idx] = it.plen;
            pf_ctry[it.idx] = it.ctry;
            pf_vld[it.idx] = it.vld;
            v.reason = gpf_pkg::R_WRITE;
            return v;
        end
        if (it.cmd == gpf_pkg::CMD_POLICY) begin
            pol_kind[it.ctry] = it.act;
            pol_lim[it.ctry] = it.lim;
            v.reason = gpf_pkg::R_WRITE;
            return v;
        end
        if (it.cmd == CMD_UNUSED) begin
            v.reason = gpf_pkg::R_WRITE;
            return v;
        end
        if (!enable_q) begin
            v.reason = gpf_pkg::R_DISABLED;
            return v;
        end
        if (it.etype != gpf_pkg::ETHERTYPE_IPV4 || it.flen < gpf_pkg::MIN_FRAME_BYTES) begin
            v.reason = gpf_pkg::R_NOT_IPV4;
            return v;
        end
        if (it.ihl < gpf_pkg::MIN_IHL) begin
            v.drop = 1'b1;
            v.reason = gpf_pkg::R_BAD_IHL;
            return v;
        end
        for (int i = 0; i < gpf_pkg::PrefixEntries; i++) begin
            if (!pf_vld[i]) continue;
            l = (pf_len[i] > 32) ? 32 : int'(pf_len[i]);
            m = (l == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - l));
            if ((it.ip & m) != (pf_addr[i] & m)) continue;
            // strict compare keeps the lowest slot on a tie
            if (!found || l > best) begin
                found = 1'b1;
                best = l;
                c = pf_ctry[i];
            end
        end
        if (!found) begin
            v.reason = gpf_pkg::R_NO_MATCH;
            return v;
        end
        v.ctry = c;
        if (pol_kind[c] == gpf_pkg::KIND_DROP) begin
            v.drop = 1'b1;
            v.reason = gpf_pkg::R_COUNTRY_DROP;
            v.geo = 1'b1;
        end else if (pol_kind[c] == gpf_pkg::KIND_RATE) begin
            v.reason = gpf_pkg::R_WITHIN;
            if (pol_lim[c] != 0) begin
                if (!cnt_vld[c] || (it.now - win_start[c]) >= {32'h0, window_q}) begin
                    cnt_vld[c] = 1'b1;
                    win_start[c] = it.now;
                    win_count[c] = 32'd1;
                end else begin
                    if (win_count[c] != 32'hFFFF_FFFF) win_count[c] = win_count[c] + 32'd1;
                    if (win_count[c] > pol_lim[c]) begin
                        v.drop = 1'b1;
                        v.reason = gpf_pkg::R_OVER;
                        v.geo = 1'b1;
                    end
                end
            end
        end else begin
            v.reason = gpf_pkg::R_ALLOW;
        end
        return v;
    endfunction

    function automatic item_t mk_pkt(input logic [31:0] ip, input logic [15:0] et,
                                     input logic [3:0] ihl, input logic [15:0] flen,
                                     input logic [63:0] now);
        item_t it;
        it = '0;
        it.cmd = gpf_pkg::CMD_PACKET;
        it.ip = ip;
        it.etype = et;
        it.ihl = ihl;
        it.flen = flen;
        it.now = now;
        return it;
    endfunction

    function automatic item_t mk_prefix(input logic [5:0] idx, input logic [31:0] addr,
                                        input logic [5:0] plen, input logic [9:0] ctry,
                                        input logic vld);
        item_t it;
        it = '0;
        it.cmd = gpf_pkg::CMD_PREFIX;
        it.idx = idx;
        it.ip = addr;
        it.plen = plen;
        it.ctry = ctry;
        it.vld = vld;
        return it;
    endfunction

    function automatic item_t mk_policy(input logic [9:0] ctry, input logic [1:0] act,
                                        input logic [31:0] lim);
        item_t it;
        it = '0;
        it.cmd = gpf_pkg::CMD_POLICY;
        it.ctry = ctry;
        it.act = act;
        it.lim = lim;
        return it;
    endfunction

    function automatic verdict_bits_t vd(input logic drop, input logic [3:0] reason);
        verdict_bits_t v;
        v = '0;
        v.drop = drop;
        v.reason = reason;
        return v;
    endfunction

    task automatic add_item(input item_t it, input logic has_exp, input verdict_bits_t exp);
        row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = gpf_pkg::REG_ENABLE;
        r.reg_val = '0;
        r.it = it;
        r.has_exp = has_exp;
        r.exp = exp;
        rows.push_back(r);
    endtask

    task automatic add_cfg(input logic idx, input logic [31:0] val);
        row_t r;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.it = '0;
        r.has_exp = 1'b0;
        r.exp = '0;
        rows.push_back(r);
    endtask

    task automatic offer(input item_t it, input logic has_exp, input verdict_bits_t exp);
        verdict_bits_t v;
        if ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, it};
        do @(posedge aclk); while (!s_axis_tready);
        v = judge_item(it);
        verdict_q.push_back(has_exp ? exp : v);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        // block must be drained before touching a register
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == gpf_pkg::REG_ENABLE) enable_q = val[0];
        else window_q = val;
    endtask

    function automatic item_t random_item();
        item_t it;
        int pick;
        int slot;
        int keep;
        it = 191'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        clock_ns = clock_ns + 64'($urandom_range(0, 60));
        if (pick < 8) begin
            // noise: every field random
            return it;
        end else if (pick < 22) begin
            it.cmd = gpf_pkg::CMD_PREFIX;
            it.ctry = 10'($urandom_range(0, 7));
            it.vld = ($urandom_range(0, 9) != 0);
            it.plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                  : 6'($urandom_range(0, 32));
            it.idx = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 15)) : it.idx;
        end else if (pick < 32) begin
            it.cmd = gpf_pkg::CMD_POLICY;
            it.ctry = 10'($urandom_range(0, 7));
            if ($urandom_range(0, 7) != 0) it.lim = $urandom_range(0, 5);
        end else if (pick < 35) begin
            it.cmd = CMD_UNUSED;
        end else begin
            it.cmd = gpf_pkg::CMD_PACKET;
            it.etype = ($urandom_range(0, 9) != 0) ? gpf_pkg::ETHERTYPE_IPV4 : it.etype;
            if ($urandom_range(0, 9) != 0 && it.flen < gpf_pkg::MIN_FRAME_BYTES)
                it.flen = 16'd1500;
            if ($urandom_range(0, 9) != 0 && it.ihl < gpf_pkg::MIN_IHL) it.ihl = 4'd5;
            if ($urandom_range(0, 4) != 0) begin
                // aim close to a stored prefix
                slot = $urandom_range(0, 15);
                keep = $urandom_range(0, 32);
                it.ip = (keep == 0) ? it.ip
                                    : ((pf_addr[slot] & (32'hFFFF_FFFF << (32 - keep)))
                                       | (it.ip & ~(32'hFFFF_FFFF << (32 - keep))));
            end
            if ($urandom_range(0, 19) == 0) clock_ns = {$urandom, $urandom};
            it.now = clock_ns;
        end
        return it;
    endfunction

    // result side: check and stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected verdict %h", m_axis_tdata);
                end else begin
                    automatic verdict_bits_t e = verdict_q.pop_front();
                    automatic verdict_bits_t a = m_axis_tdata;
                    if (a !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"verdict mismatch: exp drop=%0d reason=%0d geo=%0d",
                                      " ctry=%0d, got drop=%0d reason=%0d geo=%0d ctry=%0d"},
                                     e.drop, e.reason, e.geo, e.ctry,
                                     a.drop, a.reason, a.geo, a.ctry);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int win_set[5];
        int send_set[5];
        int stall_set[5];
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = gpf_pkg::REG_ENABLE;
        cfg_wdata = '0;
        enable_q = 1'b0;
        window_q = 32'd1000000000;
        for (int i = 0; i < gpf_pkg::PrefixEntries; i++) begin
            pf_addr[i] = '0;
            pf_len[i] = '0;
            pf_ctry[i] = '0;
            pf_vld[i] = 1'b0;
        end
        for (int i = 0; i < gpf_pkg::CountrySlots; i++) begin
            pol_kind[i] = ACT_ALLOW;
            pol_lim[i] = '0;
            win_start[i] = '0;
            win_count[i] = '0;
            cnt_vld[i] = 1'b0;
        end

        // filter off after reset, writes acknowledged
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64, 64'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_DISABLED));
        add_item('1 & ~item_t'(3), 1'b1, vd(1'b0, gpf_pkg::R_DISABLED));
        add_item(mk_prefix(6'd63, 32'hFFFF_FFFF, 6'd63, 10'd1023, 1'b0), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_policy(10'd1023, ACT_ALLOW_ALT, 32'hFFFF_FFFF), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item({{189{1'b1}}, CMD_UNUSED}, 1'b1, vd(1'b0, gpf_pkg::R_WRITE));
        add_cfg(gpf_pkg::REG_ENABLE, 32'd1);
        add_cfg(gpf_pkg::REG_WINDOW, 32'd1000);
        add_item(mk_pkt(32'h0A02_0000, 16'h86DD, 4'd5, 16'd64, 64'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_NOT_IPV4));
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd33, 64'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_NOT_IPV4));
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd4, 16'd34, 64'd0), 1'b1,
                 vd(1'b1, gpf_pkg::R_BAD_IHL));
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd0, 16'hFFFF, 64'd0), 1'b1,
                 vd(1'b1, gpf_pkg::R_BAD_IHL));
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd15, 16'd34, 64'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_NO_MATCH));
        add_item(mk_prefix(6'd5, 32'h0A00_0000, 6'd8, 10'd7, 1'b1), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_prefix(6'd6, 32'h0A01_0000, 6'd16, 10'd9, 1'b1), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        // length above the address width counts as a full match
        add_item(mk_prefix(6'd7, 32'h0A01_0203, 6'd40, 10'd11, 1'b1), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_prefix(6'd8, 32'h0AFF_0000, 6'd8, 10'd12, 1'b1), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_prefix(6'd0, 32'h0, 6'd0, 10'd1, 1'b1), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_policy(10'd9, gpf_pkg::KIND_DROP, 32'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_policy(10'd7, gpf_pkg::KIND_RATE, 32'd2), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_policy(10'd1, gpf_pkg::KIND_RATE, 32'd0), 1'b1,
                 vd(1'b0, gpf_pkg::R_WRITE));
        add_item(mk_pkt(32'h0A01_0203, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64, 64'd10),
                 1'b0, '0);
        add_item(mk_pkt(32'h0A01_0505, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64, 64'd20),
                 1'b0, '0);
        for (int k = 0; k < 3; k++)
            add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64,
                            64'(30 + k)), 1'b0, '0);
        add_item(mk_pkt(32'h0A02_0000, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64, 64'd5000),
                 1'b0, '0);
        add_item(mk_pkt(32'hC0A8_0001, gpf_pkg::ETHERTYPE_IPV4, 4'd5, 16'd64, 64'd40),
                 1'b0, '0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) write_reg(rows[r].reg_idx, rows[r].reg_val);
            else offer(rows[r].it, rows[r].has_exp, rows[r].exp);
        end
        clock_ns = 64'd6000;

        win_set = '{1000, 1, 32'hFFFF_FFFF, 50, 200};
        send_set = '{0, 68, 0, 26, 0};
        stall_set = '{0, 0, 68, 26, 0};
        for (int p = 0; p < 5; p++) begin
            write_reg(gpf_pkg::REG_ENABLE, (p == 3) ? 32'd0 : 32'd1);
            write_reg(gpf_pkg::REG_WINDOW, win_set[p]);
            send_idle = send_set[p];
            recv_stall = stall_set[p];
            if (p == 4) hold_left = HOLD_CYCLES;
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
                offer(random_item(), 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
